// ===== sv/qfs_pkg.sv =====
package qfs_pkg;

    typedef logic signed [15:0] t_comp;
    typedef logic signed [31:0] t_q;
    typedef logic signed [63:0] t_wide;

    localparam int NUM_STAGES = 22;
    localparam int FRAC_BITS  = 28;

    localparam t_q Q_ONE        = 32'sd268435456;
    localparam t_q Q_HALF       = 32'sd134217728;
    localparam t_q Q_THREE_HALF = 32'sd402653184;
    localparam t_q C_109        = 32'sd292594647;
    localparam t_q C_476        = 32'sd127919427;
    localparam t_q C_090        = 32'sd24248338;
    localparam t_q R_22680      = 32'sd11836;
    localparam t_q R_630        = 32'sd426088;
    localparam t_q R_30         = 32'sd8947849;
    localparam t_q R_3          = 32'sd89478485;

    // Series offsets; sixteen and nine do not fit in Q4.28, so they stay wide.
    localparam t_wide W_ONE     = 64'sd268435456;
    localparam t_wide W_FOUR    = 64'sd1073741824;
    localparam t_wide W_NINE    = 64'sd2415919104;
    localparam t_wide W_SIXTEEN = 64'sd4294967296;

    localparam t_wide W_QMAX = 64'sd2147483647;
    localparam t_wide W_QMIN = -64'sd2147483648;

    typedef struct packed {
        logic            byp;
        logic            neg;
        logic [15:0]     t;
        logic [3:0][15:0] a;
        logic [3:0][15:0] b;
        logic [3:0][15:0] byp_val;
        logic [3:0][31:0] vec;
        logic [3:0][31:0] sqr;
        t_q              half_y;
        t_q              f1;
        t_q              u;
        t_q              f2a;
        t_q              f2b;
        t_q              hs;
        t_q              vers;
        t_q              sq1;
        t_q              sq2;
        t_q              r2b;
        t_q              ra;
        t_q              rb;
        t_q              ma;
        t_q              mb;
        t_q              corr;
        logic [3:0][15:0] res_out;
    } t_pipe;

    function automatic t_q sat64(input t_wide v);
        if (v > W_QMAX) begin
            return 32'sh7fffffff;
        end else if (v < W_QMIN) begin
            return -32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_q qadd(input t_q a, input t_q b);
        return sat64(t_wide'(a) + t_wide'(b));
    endfunction

    function automatic t_q qsub(input t_q a, input t_q b);
        return sat64(t_wide'(a) - t_wide'(b));
    endfunction

    function automatic t_q qsubw(input t_q a, input t_wide k);
        return sat64(t_wide'(a) - k);
    endfunction

    // Product truncated toward minus infinity, then saturated.
    function automatic t_q qmul(input t_q a, input t_q b);
        t_wide p;
        p = t_wide'(a) * t_wide'(b);
        return sat64(p >>> FRAC_BITS);
    endfunction

    function automatic t_q qneg(input t_q a);
        return sat64(-t_wide'(a));
    endfunction

    function automatic logic [15:0] to_out(input t_q v);
        t_wide r;
        r = (t_wide'(v) + 64'sd8192) >>> 14;
        if (r > 64'sd32767) begin
            return 16'h7fff;
        end else if (r < -64'sd32768) begin
            return 16'h8000;
        end
        return r[15:0];
    endfunction

endpackage

// ===== sv/qfs_if.sv =====
interface qfs_in_if;
    import qfs_pkg::*;
    logic        valid;
    logic        ready;
    t_comp       first_x;
    t_comp       first_y;
    t_comp       first_z;
    t_comp       first_w;
    t_comp       second_x;
    t_comp       second_y;
    t_comp       second_z;
    t_comp       second_w;
    logic [15:0] fraction;

    modport source (
        output valid, first_x, first_y, first_z, first_w,
        output second_x, second_y, second_z, second_w, fraction,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, first_w,
        input  second_x, second_y, second_z, second_w, fraction,
        output ready
    );
endinterface

interface qfs_out_if;
    import qfs_pkg::*;
    logic  valid;
    logic  ready;
    t_comp out_x;
    t_comp out_y;
    t_comp out_z;
    t_comp out_w;

    modport source (output valid, out_x, out_y, out_z, out_w, input ready);
    modport sink (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

// ===== sv/quaternion_fast_slerp_unit.sv =====
// Throughput: one transaction per cycle while the output is ready; 22 register
// stages, each at most one Q4.28 multiply deep with a few saturating adds around it,
// and no stage shared by two items. A stalled output holds its stage; upstream stages
// keep filling any empty slots.
// Reset (i_rst_n low at a clock edge) clears every stage valid bit; data is not reset.
module quaternion_fast_slerp_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    qfs_in_if.sink    i_in,
    qfs_out_if.source o_out
);
    import qfs_pkg::*;

    t_pipe                 r_pipe [1:NUM_STAGES];
    t_pipe                 n_pipe [1:NUM_STAGES];
    logic [NUM_STAGES:1]   r_vld;
    logic [NUM_STAGES:1]   en;

    function automatic t_pipe step(input int k, input t_pipe p);
        t_pipe q;
        t_q    c;
        t_q    tq;
        t_q    f2b0;
        t_q    u0;
        t_q    f1n;
        t_q    wa;
        t_q    ea;
        t_q    eb;
        q = p;
        c = '0;
        tq = '0;
        f2b0 = '0;
        u0 = '0;
        f1n = '0;
        wa = '0;
        ea = '0;
        eb = '0;
        case (k)
            2: begin
                c = t_q'(p.vec[0]);
                c = qadd(c, t_q'(p.vec[1]));
                c = qadd(c, t_q'(p.vec[2]));
                c = qadd(c, t_q'(p.vec[3]));
                q.neg = c[31];
                q.half_y = c[31] ? qsub(Q_ONE, c) : qadd(Q_ONE, c);
                tq = t_q'({3'd0, p.t, 13'd0});
                f2b0 = tq - Q_HALF;
                u0 = f2b0[31] ? -f2b0 : f2b0;
                q.f2a = u0 - f2b0;
                q.f2b = f2b0 + u0;
                q.u = u0 + u0;
                q.f1 = Q_ONE - (u0 + u0);
            end
            3:  q.ma = qsub(C_476, qmul(C_090, p.half_y));
            4:  q.hs = qsub(C_109, qmul(p.ma, p.half_y));
            5:  q.ma = qmul(p.half_y, p.hs);
            6:  q.ma = qsub(Q_THREE_HALF, qmul(p.ma, p.hs));
            7:  q.hs = qmul(p.hs, p.ma);
            8: begin
                q.vers = qsub(Q_ONE, qmul(p.half_y, p.hs));
                q.sq1 = qmul(p.f1, p.f1);
                q.sq2 = qmul(p.u, p.u);
            end
            9:  q.r2b = qmul(R_22680, p.vers);
            10: begin
                q.ra = qadd(-R_630, qmul(qsubw(p.sq1, W_SIXTEEN), p.r2b));
                q.rb = qadd(-R_630, qmul(qsubw(p.sq2, W_SIXTEEN), p.r2b));
            end
            11: begin
                q.ma = qmul(p.ra, qsubw(p.sq1, W_NINE));
                q.mb = qmul(p.rb, qsubw(p.sq2, W_NINE));
            end
            12: begin
                q.ra = qadd(R_30, qmul(p.ma, p.vers));
                q.rb = qadd(R_30, qmul(p.mb, p.vers));
            end
            13: begin
                q.ma = qmul(p.ra, qsubw(p.sq1, W_FOUR));
                q.mb = qmul(p.rb, qsubw(p.sq2, W_FOUR));
            end
            14: begin
                q.ra = qadd(-R_3, qmul(p.ma, p.vers));
                q.rb = qadd(-R_3, qmul(p.mb, p.vers));
            end
            15: begin
                q.ma = qmul(p.ra, qsubw(p.sq1, W_ONE));
                q.mb = qmul(p.rb, qsubw(p.sq2, W_ONE));
            end
            16: begin
                q.ra = qadd(Q_ONE, qmul(p.ma, p.vers));
                q.rb = qadd(Q_ONE, qmul(p.mb, p.vers));
            end
            17: begin
                q.ma = qmul(p.ra, p.hs);
                q.f2a = qmul(p.f2a, p.rb);
                q.f2b = qmul(p.f2b, p.rb);
            end
            18: begin
                // The weight of q1 is negated when the dot product was folded.
                f1n = qmul(p.f1, p.ma);
                wa = qadd(f1n, p.f2a);
                q.ma = p.neg ? qneg(wa) : wa;
                q.mb = qadd(f1n, p.f2b);
            end
            19: begin
                for (int i = 0; i < 4; i++) begin
                    ea = {{2{p.a[i][15]}}, p.a[i], 14'd0};
                    eb = {{2{p.b[i][15]}}, p.b[i], 14'd0};
                    q.vec[i] = qadd(qmul(p.ma, ea), qmul(p.mb, eb));
                end
            end
            20: begin
                for (int i = 0; i < 4; i++) begin
                    q.sqr[i] = qmul(t_q'(p.vec[i]), t_q'(p.vec[i]));
                end
            end
            21: begin
                c = t_q'(p.sqr[0]);
                c = qadd(c, t_q'(p.sqr[1]));
                c = qadd(c, t_q'(p.sqr[2]));
                c = qadd(c, t_q'(p.sqr[3]));
                q.corr = qsub(Q_THREE_HALF, c >>> 1);
            end
            22: begin
                for (int i = 0; i < 4; i++) begin
                    q.res_out[i] = p.byp ? p.byp_val[i]
                                         : to_out(qmul(t_q'(p.vec[i]), p.corr));
                end
            end
            default: ;
        endcase
        return q;
    endfunction

    always_comb begin
        logic same;
        logic t_zero;
        logic t_full;
        n_pipe[1] = '0;
        n_pipe[1].a = {i_in.first_w, i_in.first_z, i_in.first_y, i_in.first_x};
        n_pipe[1].b = {i_in.second_w, i_in.second_z, i_in.second_y, i_in.second_x};
        n_pipe[1].t = i_in.fraction;
        same = (n_pipe[1].a == n_pipe[1].b);
        t_zero = (i_in.fraction == 16'd0);
        t_full = i_in.fraction[15];
        n_pipe[1].byp = same || t_zero || t_full;
        n_pipe[1].byp_val = (same || t_zero) ? n_pipe[1].a : n_pipe[1].b;
        for (int i = 0; i < 4; i++) begin
            n_pipe[1].vec[i] = t_q'(signed'(n_pipe[1].a[i]))
                             * t_q'(signed'(n_pipe[1].b[i]));
        end
        for (int k = 2; k <= NUM_STAGES; k++) begin
            n_pipe[k] = step(k, r_pipe[k-1]);
        end
    end

    // A stage loads when it is empty or its contents move on in the same cycle.
    always_comb begin
        en[NUM_STAGES] = !r_vld[NUM_STAGES] || o_out.ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_in.valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= NUM_STAGES; k++) begin
            if (en[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    assign i_in.ready  = en[1];
    assign o_out.valid = r_vld[NUM_STAGES];
    assign o_out.out_x = r_pipe[NUM_STAGES].res_out[0];
    assign o_out.out_y = r_pipe[NUM_STAGES].res_out[1];
    assign o_out.out_z = r_pipe[NUM_STAGES].res_out[2];
    assign o_out.out_w = r_pipe[NUM_STAGES].res_out[3];

    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");

    a_count_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> $countones(r_vld) == $past($countones(r_vld))
            + $past(i_in.valid && i_in.ready) - $past(o_out.valid && o_out.ready))
        else $error("transaction lost or duplicated in pipeline");

    a_bypass_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !r_pipe[1].byp) |-> (r_pipe[1].t != 16'd0 && !r_pipe[1].t[15]))
        else $error("interpolating path taken for an endpoint fraction");

endmodule
